[design/mspan_pkg.sv]
package mspan_pkg;

  // Default sizing of the block
  localparam int unsigned MAX_LEN_DEF = 65536;
  localparam int unsigned K_MAX_DEF   = 1024;

  // Configuration register
  localparam int unsigned K_W         = 11;
  localparam int unsigned K_RESET     = 1;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // Register index (paddr[PADDR_W-1:2])
  localparam logic [PADDR_W-3:0] REG_ZERO_RUNS = '0;

  // Commands from the run coder to the ring datapath
  typedef struct packed {
    logic push;       // write the closed run into the ring
    logic ones_run;   // the closed run is a ones-run
    logic tail_zero;  // the stream ended on a zero-run
    logic close;      // take the final span and clear the stream state
  } ring_ctl_t;

endpackage

[design/max_span_bridging_k_zero_runs.sv]
// Longest span over a serial bit stream that bridges at most k zero-runs (k is register
// zero_runs_allowed at byte address 0, clipped to K_MAX and taken only between streams).
// One bit word is accepted per cycle; the bit marked is_last goes through phases take, tail
// and done, since it closes up to two runs into the run ring and then needs the ring's
// oldest entry, which the registered ring memory returns in the cycle after the second
// write. The result, saturated at MAX_LEN, is held in an output register, so further bit
// words are accepted while it waits; a last bit waits in the done phase only if the
// previous result is still untaken. Spans near the end of the stream are cut at the end.
module max_span_bridging_k_zero_runs
  import mspan_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int K_MAX   = K_MAX_DEF,
  localparam int LEN_W  = $clog2(MAX_LEN + 1),
  localparam int CNT_W  = $clog2(2 * K_MAX + 2)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               bit_value,
  input  logic               is_last,
  output logic               span_valid,
  input  logic               span_ready,
  output logic [LEN_W-1:0]   best_span,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [1:0] PH_TAKE = 2'd0;
  localparam logic [1:0] PH_TAIL = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [LEN_W-1:0] current_run;
  logic [LEN_W-1:0] current_run_next;
  logic             prior_bit;
  logic             prior_bit_next;
  logic             started;
  logic             started_next;
  logic             take;
  logic             load;
  logic [CNT_W-1:0] wsize;
  ring_ctl_t        ctl;
  logic [LEN_W-1:0] result;

  assign item_ready = (phase == PH_TAKE);
  assign take       = item_valid && item_ready;

  mspan_cfg #(
    .K_MAX (K_MAX)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lock    (started),
    .wsize   (wsize)
  );

  mspan_ring #(
    .MAX_LEN (MAX_LEN),
    .K_MAX   (K_MAX)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .wsize  (wsize),
    .ctl    (ctl),
    .len    (current_run),
    .result (result)
  );

  always_comb begin
    phase_next       = phase;
    current_run_next = current_run;
    prior_bit_next   = prior_bit;
    started_next     = started;
    load             = 1'b0;
    ctl              = '0;
    unique case (phase)
      PH_TAKE: begin
        if (take) begin
          started_next = 1'b1;
          if (bit_value != prior_bit) begin
            // close the open run
            ctl.push         = 1'b1;
            ctl.ones_run     = prior_bit;
            current_run_next = LEN_W'(1);
            prior_bit_next   = bit_value;
          end else if (current_run < LEN_W'(MAX_LEN)) begin
            current_run_next = current_run + LEN_W'(1);
          end
          if (is_last) begin
            phase_next = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        ctl.push     = 1'b1;
        ctl.ones_run = prior_bit;
        phase_next   = PH_DONE;
      end
      PH_DONE: begin
        ctl.tail_zero = !prior_bit;
        if (!span_valid || span_ready) begin
          ctl.close        = 1'b1;
          load             = 1'b1;
          current_run_next = '0;
          prior_bit_next   = 1'b1;
          started_next     = 1'b0;
          phase_next       = PH_TAKE;
        end
      end
      default: begin
        phase_next = PH_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TAKE;
      current_run <= '0;
      prior_bit   <= 1'b1;
      started     <= 1'b0;
      span_valid  <= 1'b0;
    end else begin
      phase       <= phase_next;
      current_run <= current_run_next;
      prior_bit   <= prior_bit_next;
      started     <= started_next;
      if (load) begin
        span_valid <= 1'b1;
      end else if (span_ready) begin
        span_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      best_span <= result;
    end
  end

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (take && is_last) |=> !item_ready)
    else $error("input taken while the last bit is still closing");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(span_valid) |-> ($past(phase) == PH_DONE))
    else $error("result raised outside the closing cycle");

endmodule

[design/mspan_ram.sv]
module mspan_ram
  import mspan_pkg::*;
#(
  parameter int WIDTH = $clog2(MAX_LEN_DEF + 1),
  parameter int DEPTH = 2 * K_MAX_DEF + 1,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/mspan_cfg.sv]
module mspan_cfg
  import mspan_pkg::*;
#(
  parameter int K_MAX = K_MAX_DEF,
  localparam int DEPTH = 2 * K_MAX + 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               lock,
  output logic [CNT_W-1:0]   wsize
);

  logic [K_W-1:0] k;
  logic           sel_k;
  logic           wr_k;
  logic [31:0]    k_clip;

  assign pready = 1'b1;
  assign sel_k  = (paddr[PADDR_W-1:2] == REG_ZERO_RUNS);
  assign wr_k   = psel && penable && pwrite && sel_k && !lock;
  assign prdata = sel_k ? PDATA_W'(k) : '0;

  // clip k to the ring capacity; window is 2k+1 runs
  always_comb begin
    k_clip = 32'(pwdata[K_W-1:0]);
    if (k_clip > 32'(K_MAX)) begin
      k_clip = 32'(K_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= K_W'(K_RESET);
      wsize <= CNT_W'(2 * K_RESET + 1);
    end else if (wr_k) begin
      k     <= pwdata[K_W-1:0];
      wsize <= CNT_W'({k_clip[30:0], 1'b1});
    end
  end

endmodule

[design/mspan_ring.sv]
module mspan_ring
  import mspan_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int K_MAX   = K_MAX_DEF,
  localparam int LEN_W  = $clog2(MAX_LEN + 1),
  localparam int DEPTH  = 2 * K_MAX + 1,
  localparam int AW     = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int SUM_W  = $clog2(longint'(DEPTH) * longint'(MAX_LEN) + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] wsize,
  input  ring_ctl_t        ctl,
  input  logic [LEN_W-1:0] len,
  output logic [LEN_W-1:0] result
);

  logic [AW-1:0]    head;
  logic [AW-1:0]    head_next;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] total;
  logic [LEN_W-1:0] best;
  logic             fwd_valid;
  logic [LEN_W-1:0] fwd_data;

  logic [LEN_W-1:0] rd_data;
  logic [LEN_W-1:0] oldest;
  logic             full;
  logic [SUM_W-1:0] sub_val;
  logic [SUM_W-1:0] total_push;
  logic [CNT_W-1:0] count_push;
  logic [CNT_W-1:0] head_p1;
  logic [AW-1:0]    head_wrap;
  logic             note_push;
  logic [LEN_W-1:0] push_span;
  logic [SUM_W-1:0] cand;
  logic [LEN_W-1:0] cand_span;
  logic             cand_ok;

  function automatic logic [LEN_W-1:0] clip(input logic [SUM_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v > SUM_W'(MAX_LEN)) begin
      r = LEN_W'(MAX_LEN);
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

  // the entry at head is always prefetched: once the window is full it is the oldest held run
  mspan_ram #(
    .WIDTH (LEN_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (head),
    .wr_data (len),
    .rd_addr (head_next),
    .rd_data (rd_data)
  );

  assign oldest     = fwd_valid ? fwd_data : rd_data;
  assign full       = (count >= wsize);
  assign sub_val    = full ? SUM_W'(oldest) : '0;
  assign total_push = total - sub_val + SUM_W'(len);
  assign count_push = full ? count : count + CNT_W'(1);
  assign head_p1    = CNT_W'(head) + CNT_W'(1);
  assign head_wrap  = (head_p1 < wsize) ? head_p1[AW-1:0] : '0;
  assign note_push  = ctl.push && ctl.ones_run && (count_push == wsize);
  assign push_span  = clip(total_push);

  always_comb begin
    if (ctl.close) begin
      head_next = '0;
    end else if (ctl.push) begin
      head_next = head_wrap;
    end else begin
      head_next = head;
    end
  end

  // span for the end of the stream: whole ring if short, else cut after the oldest if it ended on a zero-run
  always_comb begin
    cand_ok = (count < wsize) || ctl.tail_zero;
    if (count < wsize) begin
      cand = total;
    end else begin
      cand = total - SUM_W'(oldest);
    end
    cand_span = clip(cand);
    if (cand_ok && (cand_span > best)) begin
      result = cand_span;
    end else begin
      result = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      total     <= '0;
      best      <= '0;
      fwd_valid <= 1'b0;
    end else begin
      head      <= head_next;
      // a one-run window rereads the entry just written
      fwd_valid <= ctl.push && (head_next == head);
      if (ctl.close) begin
        count <= '0;
        total <= '0;
        best  <= '0;
      end else if (ctl.push) begin
        count <= count_push;
        total <= total_push;
        if (note_push && (push_span > best)) begin
          best <= push_span;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= len;
  end

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    count <= wsize)
    else $error("ring holds more runs than the window");

  a_head_in_window: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(head) < wsize)
    else $error("ring head beyond the window");

  a_push_close_apart: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.close))
    else $error("push and close in the same cycle");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mspan_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN_DEF + 1);
  localparam int RING_DEPTH = 2 * K_MAX_DEF + 1;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [PADDR_W-3:0] REG_SPARE = 1;
  localparam int unsigned K_SWEEP [9] = '{0, 1, 2, 3, 1024, 5, 2047, 0, 7};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic               bit_value = 1'b0;
  logic               is_last = 1'b0;
  logic               span_valid;
  logic               span_ready = 1'b0;
  logic [LEN_W-1:0]   best_span;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 83;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_cycles = 0;
  int          error_count = 0;
  int          cfg_errors = 0;
  int          spans_checked = 0;
  int          bits_sent = 0;
  int          streams_sent = 0;

  // span predictor state
  logic [K_W-1:0]   k_cfg;
  logic [LEN_W-1:0] run_hist [RING_DEPTH];
  int unsigned      hist_head;
  int unsigned      hist_count;
  logic [31:0]      hist_sum;
  logic [LEN_W-1:0] open_len;
  logic             open_bit;
  logic [LEN_W-1:0] best_len;
  logic             in_stream;
  logic [LEN_W-1:0] span_expected [$];

  max_span_bridging_k_zero_runs dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .bit_value  (bit_value),
    .is_last    (is_last),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .best_span  (best_span),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned span_runs();
    return (k_cfg > K_MAX_DEF) ? RING_DEPTH : 2 * k_cfg + 1;
  endfunction

  function automatic void clear_stream();
    hist_head  = 0;
    hist_count = 0;
    hist_sum   = '0;
    open_len   = '0;
    open_bit   = 1'b1;
    best_len   = '0;
    in_stream  = 1'b0;
  endfunction

  function automatic void note_span(input logic [31:0] v);
    logic [31:0] sat;
    sat = (v > MAX_LEN_DEF) ? MAX_LEN_DEF : v;
    if (sat > best_len) best_len = sat[LEN_W-1:0];
  endfunction

  function automatic void close_run(input logic [LEN_W-1:0] len, input logic ones);
    int unsigned w;
    w = span_runs();
    if (hist_count >= w) hist_sum -= run_hist[hist_head];
    else hist_count++;
    run_hist[hist_head] = len;
    hist_sum += len;
    hist_head = (hist_head + 1 < w) ? hist_head + 1 : 0;
    // a ones-run closing a full window means the oldest held run is a ones-run
    if (ones && hist_count == w) note_span(hist_sum);
  endfunction

  task automatic span_model_step(input logic b, input logic last);
    in_stream = 1'b1;
    if (b == open_bit) begin
      if (open_len < MAX_LEN_DEF) open_len++;
    end else begin
      close_run(open_len, open_bit);
      open_len = LEN_W'(1);
      open_bit = b;
    end
    if (last) begin
      close_run(open_len, open_bit);
      if (hist_count < span_runs()) begin
        note_span(hist_sum);
      end else if (!open_bit) begin
        // cut span starts just after the oldest held zero-run
        note_span(hist_sum - run_hist[hist_head]);
      end
      span_expected = {span_expected, best_len};
      clear_stream();
    end
  endtask

  task automatic send_bit(input logic b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    bit_value  <= b;
    is_last    <= last;
    do @(posedge clk); while (!item_ready);
    span_model_step(b, last);
    bits_sent++;
    if (last) streams_sent++;
  endtask

  task automatic send_stream(input string s);
    for (int i = 0; i < s.len(); i++) send_bit(s[i] == "1", i == s.len() - 1);
  endtask

  task automatic random_stream(input int unsigned min_runs, input int unsigned max_runs,
                               input int unsigned long_len);
    int unsigned runs;
    int unsigned len;
    logic b;
    runs = $urandom_range(max_runs, min_runs);
    b = 1'($urandom_range(1));
    for (int r = 0; r < runs; r++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(long_len, 1) : $urandom_range(3, 1);
      for (int i = 0; i < len; i++) send_bit(b, (r == runs - 1) && (i == len - 1));
      b = ~b;
    end
  endtask

  // drop valid and hold until every span is back, then let the block settle
  task automatic wait_for_spans();
    item_valid <= 1'b0;
    while (span_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-3:0] idx,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_zero_runs(input logic [PADDR_W-3:0] idx, input logic [K_W-1:0] k);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] data;
    // junk above the field must be dropped
    data = ($urandom() & ~PDATA_W'(2 ** K_W - 1)) | PDATA_W'(k);
    apb_access(1'b1, idx, data, rd);
    if (idx == REG_ZERO_RUNS && !in_stream) k_cfg = k;
    apb_access(1'b0, REG_ZERO_RUNS, '0, rd);
    if (rd !== PDATA_W'(k_cfg)) begin
      $error("zero_runs_allowed: expected %0d, actual %0d", k_cfg, rd);
      cfg_errors++;
    end
  endtask

  task automatic test_register_access();
    set_zero_runs(REG_SPARE, 11'd9);
    set_zero_runs(REG_ZERO_RUNS, 11'(K_RESET));
  endtask

  task automatic test_directed_streams();
    send_stream("1");
    send_stream("0");
    send_stream("110100111");
    send_stream("0110010");
    wait_for_spans();
    set_zero_runs(REG_ZERO_RUNS, 11'd0);
    send_stream("10110");
    send_stream("0");
  endtask

  task automatic test_mid_stream_write();
    wait_for_spans();
    set_zero_runs(REG_ZERO_RUNS, 11'd1);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    wait_for_spans();
    set_zero_runs(REG_ZERO_RUNS, 11'd5);
    send_stream("0111");
  endtask

  task automatic test_deep_ring();
    wait_for_spans();
    send_idle_pct = 6;
    recv_idle_pct = 83;
    set_zero_runs(REG_ZERO_RUNS, 11'(K_MAX_DEF));
    random_stream(20, 30, 3);
    wait_for_spans();
    set_zero_runs(REG_ZERO_RUNS, 11'd2047);
    random_stream(20, 30, 3);
  endtask

  task automatic test_backpressure();
    wait_for_spans();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    repeat (12) random_stream(1, 3, 2);
  endtask

  task automatic test_random_streams(input int unsigned k, input int unsigned n_bits);
    int unsigned target;
    int unsigned cap;
    wait_for_spans();
    set_zero_runs(REG_ZERO_RUNS, k[K_W-1:0]);
    cap = (span_runs() > 18) ? 40 : 2 * span_runs() + 4;
    target = bits_sent + n_bits;
    while (bits_sent < target) begin
      if ($urandom_range(9) == 0) send_bit(1'($urandom_range(1)), 1'b1);
      else random_stream(1, cap, 12);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      span_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      span_ready <= 1'b0;
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      span_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      span_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_spans
    logic [LEN_W-1:0] want;
    if (!rst && span_valid && span_ready) begin
      if (span_expected.size() == 0) begin
        $error("best_span: no word expected, actual %0d", best_span);
        error_count++;
      end else begin
        want = span_expected.pop_front();
        spans_checked++;
        if (best_span !== want) begin
          $error("best_span: expected %0d, actual %0d", want, best_span);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (span_valid && span_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    k_cfg = K_W'(K_RESET);
    clear_stream();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_directed_streams();
    test_mid_stream_write();
    test_deep_ring();
    test_backpressure();
    for (int m = 0; m < 3; m++) begin
      wait_for_spans();
      send_idle_pct = (m == 0) ? 6 : (m == 1) ? 83 : 0;
      recv_idle_pct = (m == 0) ? 83 : (m == 1) ? 6 : 0;
      for (int j = 0; j < 3; j++) test_random_streams(K_SWEEP[3 * m + j], 24);
    end
    wait_for_spans();

    $display("Checked %0d spans over %0d bit words in %0d streams", spans_checked,
             bits_sent, streams_sent);
    $display("k from 0 to 2047 with clipping, mid-stream writes, a held-off receiver");
    if (error_count + cfg_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
